[rtl/mfw_pkg.sv]
// Package for the message FIFO with waiters: codes, controller states and the
// command bundle between controller and datapath. No dependencies.
package mfw_pkg;

  // Operation codes carried in the mode field
  localparam logic [1:0] MODE_POST    = 2'd0;
  localparam logic [1:0] MODE_PEND    = 2'd1;
  localparam logic [1:0] MODE_RELEASE = 2'd2;

  // Result status codes
  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_FULL     = 3'd1;
  localparam logic [2:0] STAT_EMPTY    = 3'd2;
  localparam logic [2:0] STAT_TOO_LONG = 3'd3;
  localparam logic [2:0] STAT_WAITING  = 3'd4;

  // Per-task waiting marks
  localparam logic [1:0] WAIT_FULL  = 2'h1;
  localparam logic [1:0] WAIT_EMPTY = 2'h2;
  localparam logic [1:0] WAIT_NONE  = 2'h3;

  // Configuration register indexes
  localparam logic REG_DEPTH   = 1'b0;
  localparam logic REG_MAX_LEN = 1'b1;

  localparam int unsigned WAKE_W = 32;
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned LEN_W  = 4;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_EXEC,
    CS_RESP
  } ctrl_state_e;

  typedef struct packed {
    logic cap;   // latch the input beat
    logic exec;  // run the operation on queue state
    logic load;  // load the result register
  } mfw_cmd_t;

endpackage

[rtl/mfw_ctrl.sv]
// Controller of the message FIFO with waiters: sequences capture, execute and
// result load. Depends on mfw_pkg.
module mfw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output mfw_pkg::mfw_cmd_t cmd_o
);

  mfw_pkg::ctrl_state_e state_q, state_d;
  logic                 out_valid_q, out_valid_d;
  logic                 can_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mfw_pkg::CS_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign can_load = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    in_stall_o  = 1'b1;
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      mfw_pkg::CS_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = mfw_pkg::CS_EXEC;
        end
      end
      mfw_pkg::CS_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = mfw_pkg::CS_RESP;
      end
      mfw_pkg::CS_RESP: begin
        if (can_load) begin
          cmd_o.load  = 1'b1;
          out_valid_d = 1'b1;
          in_stall_o  = 1'b0;
          if (in_valid_i) begin
            cmd_o.cap = 1'b1;
            state_d   = mfw_pkg::CS_EXEC;
          end else begin
            state_d = mfw_pkg::CS_IDLE;
          end
        end
      end
      default: begin
        state_d = mfw_pkg::CS_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  // Never overwrite a result that is still held by the receiver
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded over a held beat");

  // Every execute step is followed by the response step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> state_q == mfw_pkg::CS_RESP)
    else $error("execute not followed by response");

  // Capture only happens when the input side is open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.cap |-> !in_stall_o)
    else $error("capture while stalled");

endmodule

[rtl/mfw_datapath.sv]
// Datapath of the message FIFO with waiters: input latch, message memory,
// slot pointers, entry count, waiting marks and result register. Uses mfw_pkg.
module mfw_datapath #(
  parameter int unsigned QUEUE_SLOTS = 16,
  parameter int unsigned MSG_BYTES   = 8,
  parameter int unsigned TASKS       = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mfw_pkg::mfw_cmd_t cmd_i,
  input  logic [4:0]        cfg_depth_i,
  input  logic [3:0]        cfg_max_len_i,
  input  logic [1:0]        mode_i,
  input  logic [63:0]       message_data_i,
  input  logic [3:0]        message_length_i,
  input  logic              no_block_i,
  input  logic [4:0]        task_id_i,
  output logic [2:0]        status_o,
  output logic [63:0]       read_data_o,
  output logic [3:0]        read_length_o,
  output logic [31:0]       wake_mask_o,
  output logic [4:0]        free_entries_o
);

  localparam int unsigned DATA_W   = 8 * MSG_BYTES;
  localparam int unsigned ENTRY_W  = DATA_W + mfw_pkg::LEN_W;
  localparam int unsigned SLOT_W   = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
  localparam int unsigned CMP_W    = (SLOT_W + 1 > 5) ? SLOT_W + 1 : 5;
  localparam int unsigned MARKS    = (TASKS < mfw_pkg::WAKE_W) ? TASKS : mfw_pkg::WAKE_W;
  localparam logic [4:0]  SLOT_CAP = (QUEUE_SLOTS < 31) ? 5'(QUEUE_SLOTS) : 5'd31;
  localparam logic [3:0]  LEN_CAP  = 4'(MSG_BYTES);

  // Latched input beat
  logic [1:0]        mode_q;
  logic [DATA_W-1:0] data_q;
  logic [3:0]        len_q;
  logic              nob_q;
  logic [4:0]        task_q;
  logic [DATA_W-1:0] data_masked;

  // Queue state
  logic [SLOT_W-1:0] rd_slot_q, wr_slot_q;
  logic [4:0]        count_q;
  logic [1:0]        marks_q [MARKS];
  logic [ENTRY_W-1:0] mem [QUEUE_SLOTS];
  logic [ENTRY_W-1:0] rd_entry_q;

  // Staged result pieces
  logic [2:0]  stat_q, stat_d;
  logic [31:0] wake_q, wake_d;
  logic        pend_ok_q;

  logic [4:0]  eff_depth;
  logic [3:0]  len_limit;
  logic        full, empty, too_long;
  logic        post_ok, pend_ok, post_wait, pend_wait, rel_all;
  logic [SLOT_W-1:0] wr_next, rd_next;
  logic [CMP_W-1:0]  wr_inc, rd_inc, depth_ext;

  // Drop bytes beyond the posted length
  always_comb begin
    for (int b = 0; b < MSG_BYTES; b++) begin
      data_masked[8*b +: 8] = (4'(b) < message_length_i) ? message_data_i[8*b +: 8] : 8'h00;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      mode_q <= mode_i;
      data_q <= data_masked;
      len_q  <= message_length_i;
      nob_q  <= no_block_i;
      task_q <= task_id_i;
    end
  end

  assign eff_depth = (cfg_depth_i == 5'd0) ? 5'd1 :
                     (cfg_depth_i > SLOT_CAP) ? SLOT_CAP : cfg_depth_i;
  assign len_limit = (cfg_max_len_i > LEN_CAP) ? LEN_CAP : cfg_max_len_i;
  assign full      = count_q >= eff_depth;
  assign empty     = count_q == 5'd0;
  assign too_long  = len_q > len_limit;

  assign post_ok   = cmd_i.exec && mode_q == mfw_pkg::MODE_POST && !too_long && !full;
  assign post_wait = cmd_i.exec && mode_q == mfw_pkg::MODE_POST && !too_long && full && !nob_q;
  assign pend_ok   = cmd_i.exec && mode_q == mfw_pkg::MODE_PEND && !empty;
  assign pend_wait = cmd_i.exec && mode_q == mfw_pkg::MODE_PEND && empty && !nob_q;
  assign rel_all   = cmd_i.exec && mode_q == mfw_pkg::MODE_RELEASE;

  // Wrap slots at the depth in use
  assign depth_ext = CMP_W'(eff_depth);
  assign wr_inc    = CMP_W'(wr_slot_q) + CMP_W'(1);
  assign rd_inc    = CMP_W'(rd_slot_q) + CMP_W'(1);
  assign wr_next   = (wr_inc >= depth_ext) ? '0 : wr_inc[SLOT_W-1:0];
  assign rd_next   = (rd_inc >= depth_ext) ? '0 : rd_inc[SLOT_W-1:0];

  always_comb begin
    stat_d = mfw_pkg::STAT_OK;
    case (mode_q)
      mfw_pkg::MODE_POST: begin
        if (too_long) begin
          stat_d = mfw_pkg::STAT_TOO_LONG;
        end else if (full) begin
          stat_d = nob_q ? mfw_pkg::STAT_FULL : mfw_pkg::STAT_WAITING;
        end
      end
      mfw_pkg::MODE_PEND: begin
        if (empty) begin
          stat_d = nob_q ? mfw_pkg::STAT_EMPTY : mfw_pkg::STAT_WAITING;
        end
      end
      default: begin
        stat_d = mfw_pkg::STAT_OK;
      end
    endcase
  end

  always_comb begin
    wake_d = '0;
    for (int t = 0; t < MARKS; t++) begin
      wake_d[t] = rel_all ||
                  (post_ok && marks_q[t] == mfw_pkg::WAIT_EMPTY) ||
                  (pend_ok && marks_q[t] == mfw_pkg::WAIT_FULL);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_slot_q <= '0;
      wr_slot_q <= '0;
      count_q   <= '0;
      for (int t = 0; t < MARKS; t++) begin
        marks_q[t] <= mfw_pkg::WAIT_NONE;
      end
    end else begin
      if (post_ok) begin
        wr_slot_q <= wr_next;
        count_q   <= count_q + 5'd1;
      end
      if (pend_ok) begin
        rd_slot_q <= rd_next;
        count_q   <= count_q - 5'd1;
      end
      for (int t = 0; t < MARKS; t++) begin
        if (wake_d[t]) begin
          marks_q[t] <= mfw_pkg::WAIT_NONE;
        end else if (post_wait && task_q == 5'(t)) begin
          marks_q[t] <= mfw_pkg::WAIT_FULL;
        end else if (pend_wait && task_q == 5'(t)) begin
          marks_q[t] <= mfw_pkg::WAIT_EMPTY;
        end
      end
    end
  end

  // Message memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (post_ok) begin
      mem[wr_slot_q] <= {len_q, data_q};
    end
    if (pend_ok) begin
      rd_entry_q <= mem[rd_slot_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      stat_q    <= stat_d;
      wake_q    <= wake_d;
      pend_ok_q <= pend_ok;
    end
  end

  // Result register, held while the receiver stalls
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      status_o       <= stat_q;
      read_data_o    <= pend_ok_q ? 64'(rd_entry_q[DATA_W-1:0]) : 64'd0;
      read_length_o  <= pend_ok_q ? rd_entry_q[ENTRY_W-1 -: mfw_pkg::LEN_W] : 4'd0;
      wake_mask_o    <= wake_q;
      free_entries_o <= full ? 5'd0 : eff_depth - count_q;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    post_ok |=> count_q == $past(count_q) + 5'd1)
    else $error("post did not advance the entry count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_ok |=> count_q == $past(count_q) - 5'd1)
    else $error("pend did not drop the entry count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_d == mfw_pkg::STAT_WAITING |-> !nob_q)
    else $error("non-blocking call reported as waiting");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (post_ok || pend_ok) |-> !(post_wait || pend_wait || rel_all))
    else $error("conflicting operations in one step");

endmodule

[rtl/message_fifo_with_waiters.sv]
// Top level of the message FIFO with waiters: configuration registers on the
// APB-style port, controller and datapath. Uses mfw_pkg, mfw_ctrl, mfw_datapath.
//
// Usage:
//   Each input beat (mode, message_data, message_length, no_block, task_id)
//   posts a message, pends the oldest message, or releases all waiting tasks.
//   Every beat yields exactly one result beat: status, read_data, read_length,
//   wake_mask and free_entries. A beat moves when valid is high and stall low.
//   An input beat passes through capture, execute with memory access and
//   result load before its result is presented. A new input beat is not
//   taken while the previous one is still in execute or waiting for its
//   result load; the next input is taken in the same cycle as the previous
//   result is loaded into the output register.
//   When the receiver stalls, the result register holds its beat; one more
//   input may be taken and executed, after which in_stall_o stays high until
//   the held beat is taken.
//   Reset empties the queue (slots and count to zero), clears all waiting
//   marks and sets depth 16 and length limit 8. Message memory contents are
//   not cleared; no clearing pass is needed.
//   Registers: depth in use at byte 0, max message bytes at byte 4. Write
//   them only while the block is idle.
module message_fifo_with_waiters #(
  parameter int unsigned QUEUE_SLOTS = 16,
  parameter int unsigned MSG_BYTES   = 8,
  parameter int unsigned TASKS       = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB-style configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [63:0] message_data_i,
  input  logic [3:0]  message_length_i,
  input  logic        no_block_i,
  input  logic [4:0]  task_id_i,
  // Output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [63:0] read_data_o,
  output logic [3:0]  read_length_o,
  output logic [31:0] wake_mask_o,
  output logic [4:0]  free_entries_o
);

  logic [4:0]        depth_q;
  logic [3:0]        max_len_q;
  logic              cfg_wr;
  mfw_pkg::mfw_cmd_t cmd;

  // Zero-wait access: complete every transfer in its access cycle
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q   <= 5'd16;
      max_len_q <= 4'd8;
    end else if (cfg_wr) begin
      case (paddr[2])
        mfw_pkg::REG_DEPTH:   depth_q   <= pwdata[4:0];
        mfw_pkg::REG_MAX_LEN: max_len_q <= pwdata[3:0];
        default: begin
          depth_q <= depth_q;
        end
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (paddr[2])
      mfw_pkg::REG_DEPTH:   prdata = {27'd0, depth_q};
      mfw_pkg::REG_MAX_LEN: prdata = {28'd0, max_len_q};
      default:              prdata = 32'd0;
    endcase
  end

  mfw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  mfw_datapath #(
    .QUEUE_SLOTS (QUEUE_SLOTS),
    .MSG_BYTES   (MSG_BYTES),
    .TASKS       (TASKS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .cfg_depth_i      (depth_q),
    .cfg_max_len_i    (max_len_q),
    .mode_i           (mode_i),
    .message_data_i   (message_data_i),
    .message_length_i (message_length_i),
    .no_block_i       (no_block_i),
    .task_id_i        (task_id_i),
    .status_o         (status_o),
    .read_data_o      (read_data_o),
    .read_length_o    (read_length_o),
    .wake_mask_o      (wake_mask_o),
    .free_entries_o   (free_entries_o)
  );

endmodule
